FILE: design/assert_macros.svh
// Assertion macros used by the port checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define AST_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same, fixed message.
`define AST_CHECK(lbl, clk, rst, prop) \
  `AST_PROP(lbl, clk, rst, prop, "framer port check failed")

`endif

FILE: design/ifsf_pkg.sv
// Package for the information frame stuffing framer: constants, types, helpers.
// No dependencies.
`timescale 1ns / 1ps

package ifsf_pkg;

  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_XOR    = 8'h20;
  localparam logic [7:0] ADDR_RESET = 8'h03;
  localparam int         MAX_OUT    = 9;
  localparam int         CNT_W      = $clog2(MAX_OUT + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLAG_OPEN,
    ST_ADDR,
    ST_CTRL,
    ST_HCHK,
    ST_DATA,
    ST_CHK,
    ST_FLAG_CLOSE
  } state_t;

  typedef struct packed {
    logic [7:0] raw;
    logic       stuffable;
    logic       esc_pend;
  } stuff_req_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       done;
  } stuff_rsp_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] line_byte;
    logic       frame_end;
    logic       run_last;
  } emit_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

endpackage

FILE: design/ifsf_stuff.sv
// Shared byte-stuffing unit: escape compare and XOR for one line byte per cycle.
// Depends on ifsf_pkg.
`timescale 1ns / 1ps

module ifsf_stuff (
  input  ifsf_pkg::stuff_req_t req,
  output ifsf_pkg::stuff_rsp_t rsp
);
  import ifsf_pkg::*;

  logic esc;

  assign esc = req.stuffable && needs_esc(req.raw);

  always_comb begin
    if (req.esc_pend) begin
      rsp.line_byte = req.raw ^ ESC_XOR;
      rsp.done      = 1'b1;
    end else if (esc) begin
      rsp.line_byte = ESC_BYTE;
      rsp.done      = 1'b0;
    end else begin
      rsp.line_byte = req.raw;
      rsp.done      = 1'b1;
    end
  end

endmodule

FILE: design/ifsf_seq.sv
// Framing sequencer: walks header, payload, check and closing flag, one byte a cycle unless stalled.
// Depends on ifsf_pkg and ifsf_stuff.
`timescale 1ns / 1ps

module ifsf_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [7:0]     payload_byte,
  input  logic           end_of_frame,
  input  logic [7:0]     address_byte,
  input  logic           can_emit,
  output logic           idle,
  output ifsf_pkg::emit_t emit
);
  import ifsf_pkg::*;

  state_t           state, state_next;
  logic             esc_pend, esc_pend_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [7:0]       data, chk;
  logic             last;
  logic             seq_bit, in_frame;
  stuff_req_t       req;
  stuff_rsp_t       rsp;
  logic             fire, step_done;
  logic [CNT_W:0]   n_out;
  logic             skip_chk;

  ifsf_stuff u_stuff (
    .req (req),
    .rsp (rsp)
  );

  assign idle      = (state == ST_IDLE);
  assign fire      = !idle && can_emit;
  assign step_done = fire && rsp.done;
  assign n_out     = {1'b0, cnt} + (CNT_W+1)'(1);
  assign skip_chk  = needs_esc(chk) ? (n_out + (CNT_W+1)'(3) > (CNT_W+1)'(MAX_OUT))
                                    : (n_out + (CNT_W+1)'(2) > (CNT_W+1)'(MAX_OUT));

  always_comb begin
    req.esc_pend  = esc_pend;
    req.stuffable = 1'b1;
    case (state)
      ST_ADDR:  req.raw = address_byte;
      ST_CTRL:  req.raw = {7'd0, seq_bit};
      ST_HCHK:  req.raw = address_byte ^ {7'd0, seq_bit};
      ST_DATA:  req.raw = data;
      ST_CHK:   req.raw = chk;
      default: begin
        req.raw       = FLAG_BYTE;
        req.stuffable = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    esc_pend_next  = esc_pend;
    cnt_next       = cnt;
    emit.valid     = fire;
    emit.line_byte = rsp.line_byte;
    emit.frame_end = (state == ST_FLAG_CLOSE);
    emit.run_last  = 1'b0;
    if (idle) begin
      if (start) begin
        state_next = in_frame ? ST_DATA : ST_FLAG_OPEN;
        cnt_next   = '0;
      end
    end else if (fire) begin
      cnt_next      = cnt + CNT_W'(1);
      esc_pend_next = !rsp.done;
      if (rsp.done) begin
        case (state)
          ST_FLAG_OPEN: state_next = ST_ADDR;
          ST_ADDR:      state_next = ST_CTRL;
          ST_CTRL:      state_next = ST_HCHK;
          ST_HCHK:      state_next = ST_DATA;
          ST_DATA: begin
            if (!last) begin
              state_next    = ST_IDLE;
              emit.run_last = 1'b1;
            end else begin
              state_next = skip_chk ? ST_FLAG_CLOSE : ST_CHK;
            end
          end
          ST_CHK:       state_next = ST_FLAG_CLOSE;
          ST_FLAG_CLOSE: begin
            state_next    = ST_IDLE;
            emit.run_last = 1'b1;
          end
          default:      state_next = ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      esc_pend <= 1'b0;
      cnt      <= '0;
      seq_bit  <= 1'b0;
      in_frame <= 1'b0;
      chk      <= 8'd0;
    end else begin
      state    <= state_next;
      esc_pend <= esc_pend_next;
      cnt      <= cnt_next;
      if (idle && start) begin
        in_frame <= 1'b1;
        chk      <= (in_frame ? chk : 8'd0) ^ payload_byte;
      end
      if (step_done && state == ST_FLAG_CLOSE) begin
        in_frame <= 1'b0;
        seq_bit  <= ~seq_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (idle && start) begin
      data <= payload_byte;
      last <= end_of_frame;
    end
  end

endmodule

FILE: design/info_frame_stuffing_framer_top.sv
// Top level of the information frame stuffing framer: ports, address register, output word.
// Depends on ifsf_pkg and ifsf_seq.
//
//  channel  | direction | tdata             | side band
//  s_axis   | in        | [7:0] payload     | tlast = end_of_frame
//  m_axis   | out       | [7:0] line byte   | tlast = run_last, tuser = frame_end
//  cfg      | in        | [7:0] address     | none
//
// A word is taken while idle, then its line bytes leave through the shared stuffing unit, at most
// nine per word; the sequencer takes no new word until the last line byte of the word is emitted.
// s_tready is high only while the sequencer is idle; m_tready low with a word held stalls the sequencer.
// cfg_ready is high only while the sequencer is idle and no payload word is offered.
// rst is synchronous; it restores address 0x03, sequence bit 0 and no open frame.
`timescale 1ns / 1ps

module info_frame_stuffing_framer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] payload_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] line_byte
  output logic       m_tlast,
  output logic       m_tuser,   // [0] frame_end
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data   // [7:0] address_byte
);
  import ifsf_pkg::*;

  logic [7:0] address_byte;
  logic       idle;
  emit_t      emit;
  logic       can_emit;

  assign cfg_ready = idle && !s_tvalid;
  assign s_tready  = idle;
  assign can_emit  = !m_tvalid || m_tready;

  ifsf_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (s_tvalid),
    .payload_byte (s_tdata),
    .end_of_frame (s_tlast),
    .address_byte (address_byte),
    .can_emit     (can_emit),
    .idle         (idle),
    .emit         (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte <= ADDR_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        address_byte <= cfg_data;
      end
      if (emit.valid) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      m_tdata <= emit.line_byte;
      m_tlast <= emit.run_last;
      m_tuser <= emit.frame_end;
    end
  end

endmodule

FILE: design/ifsf_checker.sv
// Port checker for the framer top level, bound in below.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ifsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);

  // held word stays put
  `AST_CHECK(a_m_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  // every word produces at least one line byte, so input closes after a take
  `AST_CHECK(a_busy_after_take, clk, rst, s_tvalid && s_tready |=> !s_tready)
  // closing flag ends the run
  `AST_CHECK(a_close_last, clk, rst, m_tvalid && m_tuser |-> m_tlast)
  `AST_PROP(a_close_flag, clk, rst, m_tvalid && m_tuser |-> m_tdata == 8'h7E,
            "closing byte is not a flag")

endmodule

bind info_frame_stuffing_framer_top ifsf_checker u_ifsf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

FILE: test/tb_top.sv
// Self-checking bench for info_frame_stuffing_framer_top: drives payload words with frame ends,
// predicts every stuffed line word in a scoreboard class and compares each one as it leaves.
// Depends on ifsf_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_top;
  import ifsf_pkg::*;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
    logic       run_last;
  } line_word_t;

  class framer_scoreboard;
    logic [7:0] address;
    logic       open_frame;
    logic       seq_bit;
    logic [7:0] running_check;
    line_word_t due_q[$];
    line_word_t burst[MAX_OUT];
    int         burst_len;
    int         mismatches;
    int         words_in;
    int         lines_out;
    int         closes;

    function new();
      address       = ADDR_RESET;
      open_frame    = 1'b0;
      seq_bit       = 1'b0;
      running_check = 8'h00;
      burst_len     = 0;
      mismatches    = 0;
      words_in      = 0;
      lines_out     = 0;
      closes        = 0;
    endfunction

    function void set_address(logic [7:0] a);
      address = a;
    endfunction

    function bit escapable(logic [7:0] b);
      return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    // at most nine line words per payload word; extras are dropped
    function void put(logic [7:0] b, logic closing);
      if (burst_len < MAX_OUT) begin
        burst[burst_len] = '{line_byte: b, frame_end: closing, run_last: 1'b0};
        burst_len++;
      end
    endfunction

    function void put_stuffed(logic [7:0] b);
      if (escapable(b)) begin
        put(ESC_BYTE, 1'b0);
        put(b ^ ESC_XOR, 1'b0);
      end else begin
        put(b, 1'b0);
      end
    endfunction

    function void note_payload(logic [7:0] d, logic eof);
      logic [7:0] ctrl;
      int         check_len;
      int         i;
      burst_len = 0;
      words_in++;
      if (!open_frame) begin
        ctrl = {7'd0, seq_bit};
        put(FLAG_BYTE, 1'b0);
        put_stuffed(address);
        put_stuffed(ctrl);
        put_stuffed(address ^ ctrl);
        open_frame    = 1'b1;
        running_check = 8'h00;
      end
      put_stuffed(d);
      running_check = running_check ^ d;
      if (eof) begin
        // check only if it fits with the closing flag; else the flag follows the payload directly
        check_len = escapable(running_check) ? 2 : 1;
        if (burst_len + check_len + 1 <= MAX_OUT)
          put_stuffed(running_check);
        put(FLAG_BYTE, 1'b1);
        seq_bit       = ~seq_bit;
        open_frame    = 1'b0;
        running_check = 8'h00;
      end
      burst[burst_len - 1].run_last = 1'b1;
      for (i = 0; i < burst_len; i++)
        due_q.push_back(burst[i]);
    endfunction

    function void check_line(logic [7:0] b, logic fe, logic rl);
      line_word_t got;
      line_word_t want;
      got = '{line_byte: b, frame_end: fe, run_last: rl};
      lines_out++;
      if (fe)
        closes++;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected line word: byte %h frame_end %b run_last %b", b, fe, rl);
        return;
      end
      want = due_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("line word %0d: expected byte %h frame_end %b run_last %b",
                   lines_out, want.line_byte, want.frame_end, want.run_last);
          $display("line word %0d: got      byte %h frame_end %b run_last %b",
                   lines_out, b, fe, rl);
        end
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function bit failed();
      return (mismatches != 0) || (due_q.size() != 0);
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'h00;
  logic       s_tlast   = 1'b0;
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = 8'h00;

  int idle_pct  = 0;
  int stall_pct = 0;

  framer_scoreboard sb = new();

  info_frame_stuffing_framer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_payload(s_tdata, s_tlast);
      if (m_tvalid && m_tready)
        sb.check_line(m_tdata, m_tuser, m_tlast);
      if (cfg_valid && cfg_ready)
        sb.set_address(cfg_data);
    end
  end

  // enter and leave on a falling edge; valid stays up for a following word
  task send_word(input logic [7:0] d, input logic eof);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= eof;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task wait_drain;
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0)
      @(negedge clk);
  endtask

  task write_address(input logic [7:0] a);
    wait_drain;
    repeat (12) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  task run_phase(input logic [7:0] a, input int idle, input int stall, input int items);
    int sent;
    int len;
    int k;
    bit paused;
    write_address(a);
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    paused    = 1'b0;
    while (sent < items) begin
      len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 6);
      for (k = 0; k < len; k++)
        send_word(pick_byte(), k == len - 1);
      sent += len;
      // hold off once mid-phase until the line side has caught up
      if (!paused && sent >= items / 2) begin
        wait_drain;
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_pct  = 16;
    stall_pct = 16;

    // reset address, plain and escaped payloads, checks landing on flag and escape
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h7E, 1'b1);
    send_word(8'h12, 1'b0);
    send_word(8'h6F, 1'b1);
    send_word(8'h7E, 1'b0);
    send_word(8'h7D, 1'b0);
    send_word(8'h5E, 1'b1);

    // escaped and plain addresses, short frames: check dropped when it lacks room, both sequence values
    write_address(8'h7E);
    send_word(8'h7D, 1'b1);
    send_word(8'h7E, 1'b1);
    write_address(8'h7D);
    send_word(8'h7E, 1'b1);
    send_word(8'h41, 1'b1);
    write_address(8'h7C);
    send_word(8'h7D, 1'b1);
    send_word(8'h01, 1'b1);
    write_address(8'hFF);
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h7E, 1'b1);
    write_address(8'h00);
    send_word(8'hAA, 1'b0);
    send_word(8'h55, 1'b1);

    run_phase(8'($urandom_range(0, 255)), 0, 0, 25);
    run_phase(8'h7E, 88, 0, 25);
    run_phase(8'hFF, 0, 88, 25);
    run_phase(8'h00, 16, 16, 25);

    wait_drain;
    repeat (16) @(negedge clk);
    $display("Covered %0d payload words and %0d line words over %0d closed frames,",
             sb.words_in, sb.lines_out, sb.closes);
    $display("with several address settings and four idle and stall mixes; %0d mismatches.",
             sb.mismatches);
    if (!sb.failed())
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d line words outstanding", sb.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/ifsf_pkg.sv
design/ifsf_stuff.sv
design/ifsf_seq.sv
design/info_frame_stuffing_framer_top.sv
design/ifsf_checker.sv
test/tb_top.sv
